// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file wdcl_checker.sv
// no dependencies; expects clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge except while reset is high
`define AST_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define AST_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/wdcl_pkg.sv =====
// types, tag constants and phase codes for the wav data chunk locator
// no dependencies
`default_nettype none

package wdcl_pkg;

  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagData = 32'h6461_7461;

  localparam logic [15:0] FallbackReset = 16'd44;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RIFF  = 3'd1,
    PH_RSIZE = 3'd2,
    PH_WAVE  = 3'd3,
    PH_ID    = 3'd4,
    PH_SIZE  = 3'd5,
    PH_SKIP  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] data_offset;
    logic        found;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/wdcl_in_reg.sv =====
// input register stage: holds one accepted request until the parser takes it
// depends on wdcl_pkg
`default_nettype none

module wdcl_in_reg (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wdcl_pkg::item_t  in_item,
  output logic             held_valid,
  output wdcl_pkg::item_t  held_item,
  input  wire              take
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wdcl_parser.sv =====
// riff/wave walker: parse state, fallback register and one-byte step logic
// depends on wdcl_pkg
`default_nettype none

module wdcl_parser (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_wr_en,
  input  wire  [15:0]        cfg_wr_data,
  input  wire                step,
  input  wdcl_pkg::item_t    item,
  output logic               res_valid,
  output wdcl_pkg::result_t  res
);

  wdcl_pkg::phase_t phase, phase_next;
  logic [1:0]  field_byte_count, field_byte_count_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] size_shift, size_shift_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] skip_remaining, skip_remaining_next;
  logic        decided, decided_next;
  logic [15:0] fallback_offset;

  // values after the first-byte restart, before the byte is parsed
  wdcl_pkg::phase_t base_phase;
  logic [1:0]  base_count;
  logic [31:0] base_tag, base_size, base_pos, base_skip;
  logic        active;
  logic [31:0] round_size;

  always_comb begin
    base_phase = phase;
    base_count = field_byte_count;
    base_tag   = tag_shift;
    base_size  = size_shift;
    base_pos   = byte_position;
    base_skip  = skip_remaining;
    active     = !decided;
    if (item.first_byte) begin
      base_phase = wdcl_pkg::PH_RIFF;
      base_count = 2'd0;
      base_tag   = '0;
      base_size  = '0;
      base_pos   = '0;
      base_skip  = '0;
      active     = 1'b1;
    end
  end

  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    tag_shift_next        = tag_shift;
    size_shift_next       = size_shift;
    byte_position_next    = byte_position;
    skip_remaining_next   = skip_remaining;
    decided_next          = decided;
    res_valid             = 1'b0;
    res.data_offset       = {16'd0, fallback_offset};
    res.found             = 1'b0;
    round_size            = '0;

    if (active) begin
      phase_next            = base_phase;
      field_byte_count_next = base_count + 2'd1;
      tag_shift_next        = base_tag;
      size_shift_next       = {item.data_byte, base_size[31:8]};
      byte_position_next    = base_pos + 32'd1;
      skip_remaining_next   = base_skip;
      decided_next          = 1'b0;

      if (base_phase == wdcl_pkg::PH_SKIP) begin
        field_byte_count_next = base_count;
        size_shift_next       = base_size;
        skip_remaining_next   = base_skip - 32'd1;
        if (base_skip == 32'd1) begin
          phase_next = wdcl_pkg::PH_ID;
        end
      end else begin
        if (base_phase != wdcl_pkg::PH_SIZE && base_phase != wdcl_pkg::PH_RSIZE) begin
          tag_shift_next = {base_tag[23:0], item.data_byte};
        end
        if (base_count == 2'd3) begin
          case (base_phase)
            wdcl_pkg::PH_RIFF: begin
              if (tag_shift_next != wdcl_pkg::TagRiff) begin
                res_valid = 1'b1;
              end else begin
                phase_next = wdcl_pkg::PH_RSIZE;
              end
            end
            wdcl_pkg::PH_RSIZE: begin
              phase_next = wdcl_pkg::PH_WAVE;
            end
            wdcl_pkg::PH_WAVE: begin
              if (tag_shift_next != wdcl_pkg::TagWave) begin
                res_valid = 1'b1;
              end else begin
                phase_next = wdcl_pkg::PH_ID;
              end
            end
            wdcl_pkg::PH_ID: begin
              phase_next = wdcl_pkg::PH_SIZE;
            end
            wdcl_pkg::PH_SIZE: begin
              if (tag_shift_next == wdcl_pkg::TagData) begin
                res_valid       = 1'b1;
                res.data_offset = byte_position_next;
                res.found       = 1'b1;
              end else begin
                round_size          = size_shift_next + 32'd1;
                skip_remaining_next = {round_size[31:1], 1'b0};
                phase_next          = (skip_remaining_next == 32'd0) ?
                                      wdcl_pkg::PH_ID : wdcl_pkg::PH_SKIP;
              end
            end
            default: begin
              phase_next = base_phase;
            end
          endcase
        end
      end

      // end of file with nothing decided yet falls back
      if (item.last_byte && !res_valid) begin
        res_valid = 1'b1;
      end
      if (res_valid) begin
        decided_next = 1'b1;
        phase_next   = wdcl_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= wdcl_pkg::PH_IDLE;
      field_byte_count <= 2'd0;
      tag_shift        <= '0;
      size_shift       <= '0;
      byte_position    <= '0;
      skip_remaining   <= '0;
      decided          <= 1'b1;
    end else if (step) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      tag_shift        <= tag_shift_next;
      size_shift       <= size_shift_next;
      byte_position    <= byte_position_next;
      skip_remaining   <= skip_remaining_next;
      decided          <= decided_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback_offset <= wdcl_pkg::FallbackReset;
    end else if (cfg_wr_en) begin
      fallback_offset <= cfg_wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wdcl_out_reg.sv =====
// result register: holds one result until the downstream side takes it
// depends on wdcl_pkg
`default_nettype none

module wdcl_out_reg (
  input  wire                clk,
  input  wire                rst,
  input  wire                load,
  input  wire                load_valid,
  input  wdcl_pkg::result_t  load_res,
  output logic               out_valid,
  input  wire                out_ready,
  output wdcl_pkg::result_t  out_res,
  output logic               free
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      out_res <= load_res;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wav_data_chunk_locator.sv =====
// wav data chunk locator top level; uses wdcl_pkg, wdcl_in_reg, wdcl_parser, wdcl_out_reg
// a result shows on m_axis from the result register, loaded by the parser step that takes the deciding byte
// throughput: one byte per cycle while the result register is free, set by the parser state update
// a stalled result register holds the parser; the input register still takes one byte
// reset (rst, synchronous, active high) empties both registers, idles the parser,
// and sets the fallback offset to 44
`default_nettype none

module wav_data_chunk_locator (
  input  wire         clk,
  input  wire         rst,
  // configuration: fallback offset
  input  wire         cfg_wr_en,
  input  wire  [15:0] cfg_wr_data,
  // byte stream in
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire  [0:0]  s_axis_tuser,   // [0] first_byte
  input  wire         s_axis_tlast,   // last_byte
  // located offset out
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] data_offset
  output logic [0:0]  m_axis_tuser    // [0] found
);

  wdcl_pkg::item_t   in_item;
  wdcl_pkg::item_t   held_item;
  wdcl_pkg::result_t res;
  wdcl_pkg::result_t out_res;
  logic              held_valid;
  logic              res_valid;
  logic              out_free;
  logic              step;

  // pack the stream fields into the request
  assign in_item.data_byte  = s_axis_tdata;
  assign in_item.first_byte = s_axis_tuser[0];
  assign in_item.last_byte  = s_axis_tlast;

  // parser moves one held byte whenever the result register can take its outcome
  assign step = held_valid && out_free;

  wdcl_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (step)
  );

  // tag checks, size capture, skip countdown and offset count
  wdcl_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (held_item),
    .res_valid   (res_valid),
    .res         (res)
  );

  // at most one result per file, held until taken
  wdcl_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (step),
    .load_valid (res_valid),
    .load_res   (res),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (out_res),
    .free       (out_free)
  );

  assign m_axis_tdata    = out_res.data_offset;
  assign m_axis_tuser[0] = out_res.found;

endmodule

`default_nettype wire

// ===== hdl/wdcl_checker.sv =====
// port-level checks for wav_data_chunk_locator, attached by bind
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module wdcl_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire [0:0]  m_axis_tuser
);

  // a stalled result keeps its value
  `AST_RUN(a_out_hold,
           m_axis_tvalid && !m_axis_tready |=>
             m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
           "result changed while stalled")

  // input only backs up behind a stalled result
  `AST_RUN(a_stall_cause,
           !s_axis_tready |-> m_axis_tvalid && !m_axis_tready,
           "input stalled without an output stall")

  // a fallback result carries a 16-bit offset
  `AST_RUN(a_fallback_width,
           m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:16] == 16'd0,
           "fallback offset wider than 16 bits")

  // nothing shows right after reset
  `AST_ALL(a_reset_empty, rst |=> !m_axis_tvalid, "result shown after reset")

endmodule

bind wav_data_chunk_locator wdcl_checker u_wdcl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
